>>> rtl/mss_pkg.sv
// Package for the marching-squares segment stream: beat types and the
// fixed per-case segment table. No dependencies.
`default_nettype none
package mss_pkg;

  // Sample width, signed Q15.16
  localparam int VALUE_BITS = 32;
  localparam int COORD_BITS = 8;
  localparam int CASE_BITS  = 4;

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL     = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_SIDE = 4'd1;

  // Case ids: the two saddle cases, which carry two segments, and the empty and full cases
  localparam logic [CASE_BITS-1:0] CASE_SADDLE_A = 4'd5;
  localparam logic [CASE_BITS-1:0] CASE_SADDLE_B = 4'd10;
  localparam logic [CASE_BITS-1:0] CASE_EMPTY    = 4'd0;
  localparam logic [CASE_BITS-1:0] CASE_FULL     = 4'd15;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample;
    logic                         frame_start;
  } mss_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [CASE_BITS-1:0]  cell_case;
    logic                  last;
  } mss_out_t;

  // Segments per case
  localparam logic [1:0] SEG_COUNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
  };

  // Offsets {xs, ys, xe, ye}, two bits each, per case and segment slot
  localparam logic [7:0] SEG_TAB [16][2] = '{
    '{8'b00_00_00_00, 8'b00_00_00_00},
    '{8'b00_00_01_00, 8'b00_00_00_00},
    '{8'b10_00_10_01, 8'b00_00_00_00},
    '{8'b00_01_10_01, 8'b00_00_00_00},
    '{8'b10_10_01_10, 8'b00_00_00_00},
    '{8'b00_00_01_00, 8'b10_10_01_10},
    '{8'b01_00_01_10, 8'b00_00_00_00},
    '{8'b00_01_01_10, 8'b00_00_00_00},
    '{8'b00_01_01_10, 8'b00_00_00_00},
    '{8'b01_00_01_10, 8'b00_00_00_00},
    '{8'b10_00_10_01, 8'b00_10_01_10},
    '{8'b10_10_01_10, 8'b00_00_00_00},
    '{8'b00_01_10_01, 8'b00_00_00_00},
    '{8'b10_00_10_01, 8'b00_00_00_00},
    '{8'b00_00_01_00, 8'b00_00_00_00},
    '{8'b00_00_00_00, 8'b00_00_00_00}
  };

endpackage
`default_nettype wire

>>> rtl/marching_squares_segment_stream_top.sv
// A sample is held in the cell stage registers, then its segments enter the output queue.
// Throughput: one sample per cycle while the queue has room; a saddle puts two segments into
//   the two-entry queue; a saddle behind another waits while it drains one segment per beat.
// Reset (rst, synchronous): clears position counters, corner marks, the pipeline and the
//   output queue. The row mark store is not cleared; entries are valid once written.
// Depends on mss_pkg.
`default_nettype none
module marching_squares_segment_stream_top
  import mss_pkg::*;
#(
  parameter int GRID_SIZE = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire mss_in_t                   in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output mss_out_t                       out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CW   = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int GW   = $clog2(GRID_SIZE + 1);
  localparam int CMPW = (GW > COORD_BITS) ? GW : COORD_BITS;

  // Configuration registers
  logic signed [VALUE_BITS-1:0] level;
  logic [7:0]                   grid_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      grid_side <= 8'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL:     level     <= cfg_data[VALUE_BITS-1:0];
        CFG_GRID_SIDE: grid_side <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective side, clamped to [2, GRID_SIZE]
  logic [CMPW-1:0] side_ext;
  logic [GW-1:0]   side_eff;

  always_comb begin
    side_ext = CMPW'(grid_side);
    if (side_ext < CMPW'(2))
      side_eff = GW'(2);
    else if (side_ext > CMPW'(GRID_SIZE))
      side_eff = GW'(GRID_SIZE);
    else
      side_eff = GW'(side_ext);
  end

  // Input side: position counters and compare
  logic          accept;
  logic          a_move;
  logic [CW-1:0] inner_count, inner_count_next;
  logic [CW-1:0] outer_count, outer_count_next;
  logic [CW-1:0] n_cur, o_cur;
  logic          m_cur;

  assign accept = in_valid && !in_stall;

  always_comb begin
    n_cur = in_data.frame_start ? '0 : inner_count;
    o_cur = in_data.frame_start ? '0 : outer_count;
    m_cur = in_data.sample > level;
    if (GW'(n_cur) + GW'(1) >= side_eff) begin
      inner_count_next = '0;
      outer_count_next = (GW'(o_cur) + GW'(1) >= side_eff) ? '0 : o_cur + CW'(1);
    end else begin
      inner_count_next = n_cur + CW'(1);
      outer_count_next = o_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_count <= '0;
      outer_count <= '0;
    end else if (accept) begin
      inner_count <= inner_count_next;
      outer_count <= outer_count_next;
    end
  end

  // Cell stage registers
  logic          a_valid;
  logic          a_m;
  logic [CW-1:0] a_n;
  logic [CW-1:0] a_o;
  logic          a_fwd;
  logic          a_fwd_m;
  logic          a_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_m     <= m_cur;
      a_n     <= n_cur;
      a_o     <= o_cur;
      // bypass when the cell stage writes the same column this cycle
      a_fwd   <= a_move && (a_n == n_cur);
      a_fwd_m <= a_m;
    end
  end

  // Row mark store: one bit per column, read-before-write
  logic row_marks [GRID_SIZE];

  always_ff @(posedge clk) begin
    if (a_move) begin
      row_marks[a_n] <= a_m;
    end
    if (accept) begin
      a_rd <= row_marks[n_cur];
    end
  end

  // Corner marks of the previous column
  logic left_mark;
  logic left_above_mark;
  logic above_here;

  assign above_here = a_fwd ? a_fwd_m : a_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mark       <= 1'b0;
      left_above_mark <= 1'b0;
    end else if (a_move) begin
      left_mark       <= a_m;
      left_above_mark <= above_here;
    end
  end

  // Case id and segments of the completed cell
  logic [CASE_BITS-1:0]  cid;
  logic                  in_cell;
  logic [1:0]            a_cnt;
  logic [COORD_BITS-1:0] bx, by;
  logic [7:0]            off0, off1;
  mss_out_t              seg0, seg1;

  always_comb begin
    cid     = {above_here, a_m, left_mark, left_above_mark};
    in_cell = (a_o != '0) && (a_n != '0);
    a_cnt   = in_cell ? SEG_COUNT[cid] : 2'd0;
    bx      = COORD_BITS'({a_o - CW'(1), 1'b0});
    by      = COORD_BITS'({a_n - CW'(1), 1'b0});
    off0    = SEG_TAB[cid][0];
    off1    = SEG_TAB[cid][1];

    seg0.x_start   = bx + COORD_BITS'(off0[7:6]);
    seg0.y_start   = by + COORD_BITS'(off0[5:4]);
    seg0.x_end     = bx + COORD_BITS'(off0[3:2]);
    seg0.y_end     = by + COORD_BITS'(off0[1:0]);
    seg0.cell_case = cid;
    seg0.last      = (a_cnt == 2'd1);

    seg1.x_start   = bx + COORD_BITS'(off1[7:6]);
    seg1.y_start   = by + COORD_BITS'(off1[5:4]);
    seg1.x_end     = bx + COORD_BITS'(off1[3:2]);
    seg1.y_end     = by + COORD_BITS'(off1[1:0]);
    seg1.cell_case = cid;
    seg1.last      = 1'b1;
  end

  // Two-entry output queue; slot 0 is the presented beat
  mss_out_t q0, q0_next;
  mss_out_t q1, q1_next;
  logic [1:0] q_cnt, q_cnt_next;
  logic [1:0] keep_n;
  logic [1:0] push_n;
  logic       pop;
  logic       room;

  assign out_valid = (q_cnt != 2'd0);
  assign out_data  = q0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    keep_n   = q_cnt - {1'b0, pop};
    room     = ({1'b0, keep_n} + {1'b0, a_cnt}) <= 3'd2;
    a_move   = a_valid && room;
    in_stall = a_valid && !room;
    push_n   = a_move ? a_cnt : 2'd0;

    q0_next = pop ? q1 : q0;
    q1_next = q1;
    if (keep_n == 2'd0) begin
      q0_next = seg0;
      q1_next = seg1;
    end else if (keep_n == 2'd1) begin
      q1_next = seg0;
    end
    q_cnt_next = keep_n + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule
`default_nettype wire

>>> rtl/mss_checker.sv
// Port-level checks for the segment stream top level, attached by bind.
// Depends on mss_pkg.
`default_nettype none
module mss_checker
  import mss_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire mss_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire mss_out_t out_data
);

  // A stalled input beat holds
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // A stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Empty and full cells never produce a segment
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cell_case != CASE_EMPTY) && (out_data.cell_case != CASE_FULL))
    else $error("segment from an empty or full cell");

  // Only saddle cells have a non-final segment
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |->
      (out_data.cell_case == CASE_SADDLE_A) || (out_data.cell_case == CASE_SADDLE_B))
    else $error("non-final segment outside a saddle case");

  // The second saddle segment follows right behind the first
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.last && $stable(out_data.cell_case))
    else $error("second saddle segment missing");

endmodule

bind marching_squares_segment_stream_top mss_checker u_mss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/mss_segment_checker.sv
// Scoreboard for the marching-squares segment stream: tracks config writes and
// sample beats, predicts the segments of each cell and checks every output beat.
// Depends on mss_pkg.
module mss_segment_checker
  import mss_pkg::*;
#(
  parameter int LINE_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  mss_in_t                   in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  mss_out_t                  out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        segs_pending,
  output int                        error_count
);

  // Shadow of the block: registers, line of marks, corner marks, position
  logic signed [VALUE_BITS-1:0] level_q;
  logic [7:0]                   side_q;
  bit [LINE_DEPTH-1:0]          row_marks;
  bit                           left_mark;
  bit                           left_above;
  int unsigned                  col;
  int unsigned                  row;
  mss_out_t                     seg_q [$];

  initial begin
    segs_pending = 0;
    error_count  = 0;
  end

  function automatic int unsigned side_in_use();
    int unsigned g;
    g = side_q;
    if (g < 2) g = 2;
    if (g > LINE_DEPTH) g = LINE_DEPTH;
    return g;
  endfunction

  // Offsets {xs, ys, xe, ye}, two bits each, for one segment slot of a case
  function automatic logic [7:0] seg_offsets(input logic [CASE_BITS-1:0] cid, input bit second);
    logic [7:0] o;
    case (cid)
      4'd1, 4'd14:   o = {2'd0, 2'd0, 2'd1, 2'd0};
      4'd2, 4'd13:   o = {2'd2, 2'd0, 2'd2, 2'd1};
      4'd3, 4'd12:   o = {2'd0, 2'd1, 2'd2, 2'd1};
      4'd4, 4'd11:   o = {2'd2, 2'd2, 2'd1, 2'd2};
      4'd6, 4'd9:    o = {2'd1, 2'd0, 2'd1, 2'd2};
      4'd7, 4'd8:    o = {2'd0, 2'd1, 2'd1, 2'd2};
      CASE_SADDLE_A: o = second ? {2'd2, 2'd2, 2'd1, 2'd2} : {2'd0, 2'd0, 2'd1, 2'd0};
      CASE_SADDLE_B: o = second ? {2'd0, 2'd2, 2'd1, 2'd2} : {2'd2, 2'd0, 2'd2, 2'd1};
      default:       o = '0;
    endcase
    return o;
  endfunction

  // One sample beat: close the cell to its upper left, then advance position
  task automatic place_sample(input mss_in_t beat);
    int unsigned          g;
    int                   nsegs;
    bit                   here;
    bit                   above_here;
    logic [CASE_BITS-1:0] cid;
    logic [7:0]           ofs;
    mss_out_t             seg;
    g = side_in_use();
    if (beat.frame_start) begin
      col = 0;
      row = 0;
    end
    here       = (beat.sample > level_q);
    above_here = row_marks[col % LINE_DEPTH];
    if (row >= 1 && col >= 1) begin
      cid = {above_here, here, left_mark, left_above};
      if (cid == CASE_EMPTY || cid == CASE_FULL) nsegs = 0;
      else if (cid == CASE_SADDLE_A || cid == CASE_SADDLE_B) nsegs = 2;
      else nsegs = 1;
      for (int k = 0; k < nsegs; k++) begin
        ofs           = seg_offsets(cid, k == 1);
        seg.x_start   = 8'(2 * (row - 1) + ofs[7:6]);
        seg.y_start   = 8'(2 * (col - 1) + ofs[5:4]);
        seg.x_end     = 8'(2 * (row - 1) + ofs[3:2]);
        seg.y_end     = 8'(2 * (col - 1) + ofs[1:0]);
        seg.cell_case = cid;
        seg.last      = (k == nsegs - 1);
        seg_q.push_back(seg);
      end
    end
    left_above                   = above_here;
    row_marks[col % LINE_DEPTH]  = here;
    left_mark                    = here;
    if (col + 1 >= g) begin
      col = 0;
      row = (row + 1 >= g) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_segment(input mss_out_t got);
    mss_out_t want;
    if (seg_q.size() == 0) begin
      error_count++;
      $display("%0t: segment beat with none expected, expected none actual %h", $time, got);
      return;
    end
    want = seg_q.pop_front();
    compare_field("x_start", want.x_start, got.x_start);
    compare_field("y_start", want.y_start, got.y_start);
    compare_field("x_end", want.x_end, got.x_end);
    compare_field("y_end", want.y_end, got.y_end);
    compare_field("cell_case", want.cell_case, got.cell_case);
    compare_field("last", want.last, got.last);
  endtask

  // Output beats first: nothing accepted at this edge can show up at it.
  // A sample taken at the same edge as a register write still sees the old value.
  always @(posedge clk) begin
    if (rst) begin
      level_q      = '0;
      side_q       = 8'd100;
      left_mark    = 1'b0;
      left_above   = 1'b0;
      col          = 0;
      row          = 0;
      seg_q.delete();
      segs_pending = 0;
    end else begin
      if (out_valid && !out_stall) check_segment(out_data);
      if (in_valid && !in_stall) place_sample(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL:     level_q = cfg_data;
          CFG_GRID_SIDE: side_q  = cfg_data[7:0];
          default: ;
        endcase
      end
      segs_pending = seg_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for marching_squares_segment_stream_top: clock, reset, config
// writes and sample stimulus, watchdog and verdict. Checking is in
// mss_segment_checker. Depends on mss_pkg and the block.
module tb_top;
  import mss_pkg::*;

  localparam int LINE_DEPTH  = 128;
  localparam int STALL_LIMIT = 4000;

  // Corner marks for the opening two rows: bit0 row 0, bit1 row 1
  localparam logic [1:0] CORNER_WALK [13] = '{
    2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2
  };

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  mss_in_t                   in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  mss_out_t                  out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_LEVEL;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int segs_pending;
  int error_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  marching_squares_segment_stream_top #(
    .GRID_SIZE(LINE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mss_segment_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .segs_pending (segs_pending),
    .error_count  (error_count)
  );

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sender gaps, then one sample beat held until taken
  task automatic send_sample(input logic signed [VALUE_BITS-1:0] value, input logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid              <= 1'b1;
    in_data.sample        <= value;
    in_data.frame_start   <= first;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and let every segment out, then wait on for samples whose cells give none
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (segs_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly values close to the level so cells mix corners, some anywhere
  function automatic logic signed [VALUE_BITS-1:0] pick_sample(
    input logic signed [VALUE_BITS-1:0] lvl);
    longint      v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 55) v = longint'(lvl) + longint'(int'($urandom_range(0, 6))) - 3;
    else v = longint'(lvl) + longint'(int'($urandom_range(0, 262144))) - 131072;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[VALUE_BITS-1:0];
  endfunction

  // One setting of the registers and a run of samples; a phase that keeps the
  // frame going only ever lowers the side, so no unwritten mark is read
  task automatic run_phase(input logic signed [VALUE_BITS-1:0] lvl, input logic [7:0] side,
                           input int count, input int send_pct, input int stall_pct,
                           input bit new_frame);
    wait_drained();
    write_reg(CFG_LEVEL, lvl);
    write_reg(CFG_GRID_SIDE, {24'd0, side});
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++)
      send_sample(pick_sample(lvl), (k == 0 && new_frame) || ($urandom_range(0, 99) < 2));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: two rows walking through most corner combinations, extremes and values next to the level as values
    write_reg(CFG_LEVEL, '0);
    write_reg(CFG_GRID_SIDE, 32'd13);
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 13; j++) begin
        if (CORNER_WALK[j][r])
          send_sample((j % 2) ? 32'sh7FFFFFFF : 32'sd1, r == 0 && j == 0);
        else
          send_sample((j % 2) ? 32'sh80000000 : 32'sd0, r == 0 && j == 0);
      end
    end

    // Random phases over levels, sides and idle patterns
    run_phase(32'sd0, 8'd5, 150, 0, 0, 1'b1);
    run_phase(32'sh7FFFFFFF, 8'd2, 60, 51, 0, 1'b1);
    run_phase(32'sh80000000, 8'd0, 60, 0, 51, 1'b1);
    run_phase($urandom, 8'd128, 300, 26, 26, 1'b1);
    run_phase(32'shFFFB0000, 8'd7, 60, 0, 0, 1'b1);
    run_phase(32'shFFFB0000, 8'd3, 100, 51, 0, 1'b0);
    run_phase($urandom, 8'd255, 200, 0, 51, 1'b1);
    run_phase($urandom, 8'd1, 100, 26, 26, 1'b1);
    run_phase($urandom, 8'd16, 150, 0, 0, 1'b1);
    run_phase(32'sd0, 8'd9, 100, 26, 26, 1'b1);

    wait_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0 && segs_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> marching_squares_segment_stream_top.f
rtl/mss_pkg.sv
rtl/marching_squares_segment_stream_top.sv
rtl/mss_checker.sv
tb/mss_segment_checker.sv
tb/tb_top.sv
